@@ sv/pic_pkg.sv @@
// Shared types, constants and codes for the PE image checksum block.
package pic_pkg;

    // Width of the byte counter; positions wrap modulo 2**LENGTH_BITS.
    localparam int LENGTH_BITS = 32;

    localparam int DOS_BYTES = 64;
    localparam int DOS_WORDS = DOS_BYTES / 2;
    localparam int DOS_AW    = $clog2(DOS_WORDS);

    localparam logic [LENGTH_BITS-1:0] DOS_CNT    = LENGTH_BITS'(DOS_BYTES);
    localparam logic [LENGTH_BITS-1:0] CNT_OFS_LO = LENGTH_BITS'(DOS_BYTES - 4);
    localparam logic [LENGTH_BITS-1:0] CNT_OFS_HI = LENGTH_BITS'(DOS_BYTES - 2);

    // Word slots of the header offset inside the DOS header.
    localparam logic [DOS_AW-1:0] WORD_OFS_LO = DOS_AW'(DOS_WORDS - 2);
    localparam logic [DOS_AW-1:0] WORD_OFS_HI = DOS_AW'(DOS_WORDS - 1);

    // Distances from the header offset.
    localparam logic [7:0] D_MAGIC_LO  = 8'd24;
    localparam logic [7:0] D_MAGIC_HI  = 8'd25;
    localparam logic [7:0] D_CSUM      = 8'd88;
    localparam logic [7:0] D_CSUM_LAST = 8'd91;

    // Largest offset whose first magic byte still falls in the DOS header.
    localparam logic [15:0] SCAN_LIMIT = 16'(DOS_BYTES - 1 - 24);

    localparam logic [15:0] MAGIC_PE32 = 16'h010B;
    localparam logic [15:0] MAGIC_PE64 = 16'h020B;

    localparam int SEEN_MAGIC = 0;
    localparam int SEEN_CSUM  = 1;

    typedef enum logic [1:0] {
        ST_ADJUSTED  = 2'd0,
        ST_PLAIN     = 2'd1,
        ST_BAD_MAGIC = 2'd2,
        ST_BEYOND    = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] data_word;
        logic        last_word;
        logic        final_half;
    } word_item_t;

    typedef struct packed {
        logic [31:0] image_checksum;
        logic [31:0] stored_checksum;
        status_t     status;
    } result_item_t;

    // End-of-file snapshot handed from the accumulator to the finishing stages.
    typedef struct packed {
        logic [16:0]            sum;
        logic [LENGTH_BITS-1:0] count;
        logic [31:0]            field;
        status_t                status;
    } snap_t;

endpackage

@@ sv/pic_accum.sv @@
// Running sum, byte counter, DOS header store and header field capture.
module pic_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  pic_pkg::word_item_t item,
    output pic_pkg::snap_t      snap
);

    logic [15:0] dos_mem [pic_pkg::DOS_WORDS];

    logic [16:0]                     sum_reg, sum_next, sum_upd;
    logic [pic_pkg::LENGTH_BITS-1:0] cnt_reg, cnt_next, cnt_upd;
    logic [31:0]                     offset_reg, offset_next, offset_upd;
    logic [15:0]                     magic_reg, magic_next, magic_upd;
    logic [31:0]                     csum_reg, csum_next, csum_upd;
    logic [1:0]                      seen_reg, seen_next, seen_upd;

    logic [15:0] rd_a_reg, rd_b_reg, off_lo_reg;

    logic        half;
    logic [15:0] w;
    logic [17:0] sum_wide;
    logic        in_dos, at_lo, at_hi, scan;

    logic [5:0]                  rd_pos, sc_pos;
    logic [pic_pkg::DOS_AW-1:0]  rd_ia, rd_ib, sc_ia, sc_ib;
    logic [15:0]                 wa, wb;
    logic [7:0]                  sc_lo_b, sc_hi_b;
    logic                        sc_lo, sc_hi;

    logic [32:0] diff;
    logic        near;
    logic [7:0]  byte_v [2];
    logic [7:0]  dist_v [2];
    logic        take_v [2];

    assign half = item.last_word & item.final_half;
    assign w    = half ? {8'h00, item.data_word[7:0]} : item.data_word;

    assign in_dos = cnt_reg < pic_pkg::DOS_CNT;
    assign at_lo  = cnt_reg == pic_pkg::CNT_OFS_LO;
    assign at_hi  = cnt_reg == pic_pkg::CNT_OFS_HI;
    assign scan   = at_hi & ~half;

    // Magic location prefetch while the low offset word goes past
    assign rd_pos = 6'(w[5:0]) + 6'(pic_pkg::D_MAGIC_LO);
    assign rd_ia  = rd_pos[5:1];
    assign rd_ib  = rd_ia + 1'b1;

    always_ff @(posedge clk)
    begin
        if (step && in_dos)
        begin
            dos_mem[cnt_reg[5:1]] <= w;
        end
        if (step && at_lo)
        begin
            rd_a_reg   <= dos_mem[rd_ia];
            rd_b_reg   <= dos_mem[rd_ib];
            off_lo_reg <= w;
        end
    end

    // Scan of the DOS header when its last byte arrives
    assign sc_pos  = 6'(off_lo_reg[5:0]) + 6'(pic_pkg::D_MAGIC_LO);
    assign sc_ia   = sc_pos[5:1];
    assign sc_ib   = sc_ia + 1'b1;
    assign wa      = (sc_ia == pic_pkg::WORD_OFS_HI) ? w :
                     (sc_ia == pic_pkg::WORD_OFS_LO) ? off_lo_reg : rd_a_reg;
    assign wb      = (sc_ib == pic_pkg::WORD_OFS_HI) ? w :
                     (sc_ib == pic_pkg::WORD_OFS_LO) ? off_lo_reg : rd_b_reg;
    assign sc_lo_b = off_lo_reg[0] ? wa[15:8] : wa[7:0];
    assign sc_hi_b = off_lo_reg[0] ? wb[7:0]  : wa[15:8];
    assign sc_lo   = (w == 16'h0000) && (off_lo_reg <= pic_pkg::SCAN_LIMIT);
    assign sc_hi   = (w == 16'h0000) && (off_lo_reg <  pic_pkg::SCAN_LIMIT);

    // Distance of this word's bytes from the header offset
    assign diff      = 33'(cnt_reg) - {1'b0, offset_reg};
    assign near      = ~diff[32] && (diff[31:7] == '0);
    assign dist_v[0] = {1'b0, diff[6:0]};
    assign dist_v[1] = dist_v[0] + 8'd1;
    assign byte_v[0] = w[7:0];
    assign byte_v[1] = w[15:8];
    assign take_v[0] = 1'b1;
    assign take_v[1] = ~half;

    assign sum_wide = 18'(sum_reg) + 18'(w);
    assign sum_upd  = 17'(sum_wide[17:16]) + 17'(sum_wide[15:0]);
    assign cnt_upd  = cnt_reg + (half ? pic_pkg::LENGTH_BITS'(1) : pic_pkg::LENGTH_BITS'(2));

    always_comb
    begin
        magic_upd  = magic_reg;
        csum_upd   = csum_reg;
        seen_upd   = seen_reg;
        offset_upd = offset_reg;
        if (!in_dos && near)
        begin
            for (int j = 0; j < 2; j++)
            begin
                if (take_v[j])
                begin
                    if (dist_v[j] == pic_pkg::D_MAGIC_LO)
                    begin
                        magic_upd[7:0] = byte_v[j];
                    end
                    else if (dist_v[j] == pic_pkg::D_MAGIC_HI)
                    begin
                        magic_upd[15:8]               = byte_v[j];
                        seen_upd[pic_pkg::SEEN_MAGIC] = 1'b1;
                    end
                    else if (dist_v[j] inside {[pic_pkg::D_CSUM:pic_pkg::D_CSUM_LAST]})
                    begin
                        csum_upd[{dist_v[j][1:0], 3'b000} +: 8] = byte_v[j];
                        if (dist_v[j] == pic_pkg::D_CSUM_LAST)
                        begin
                            seen_upd[pic_pkg::SEEN_CSUM] = 1'b1;
                        end
                    end
                end
            end
        end
        if (scan)
        begin
            offset_upd = {w, off_lo_reg};
            if (sc_lo)
            begin
                magic_upd[7:0] = sc_lo_b;
            end
            if (sc_hi)
            begin
                magic_upd[15:8]               = sc_hi_b;
                seen_upd[pic_pkg::SEEN_MAGIC] = 1'b1;
            end
        end
    end

    // Snapshot of the state after this word
    always_comb
    begin
        if (cnt_upd < pic_pkg::DOS_CNT || offset_upd == 32'h0)
        begin
            snap.status = pic_pkg::ST_PLAIN;
        end
        else if (!seen_upd[pic_pkg::SEEN_MAGIC])
        begin
            snap.status = pic_pkg::ST_BEYOND;
        end
        else if (magic_upd != pic_pkg::MAGIC_PE32 && magic_upd != pic_pkg::MAGIC_PE64)
        begin
            snap.status = pic_pkg::ST_BAD_MAGIC;
        end
        else if (!seen_upd[pic_pkg::SEEN_CSUM])
        begin
            snap.status = pic_pkg::ST_BEYOND;
        end
        else
        begin
            snap.status = pic_pkg::ST_ADJUSTED;
        end
        snap.sum   = sum_upd;
        snap.count = cnt_upd;
        snap.field = (snap.status == pic_pkg::ST_ADJUSTED) ? csum_upd : 32'h0;
    end

    always_comb
    begin
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        offset_next = offset_reg;
        magic_next  = magic_reg;
        csum_next   = csum_reg;
        seen_next   = seen_reg;
        if (step)
        begin
            if (item.last_word)
            begin
                sum_next    = '0;
                cnt_next    = '0;
                offset_next = '0;
                magic_next  = '0;
                csum_next   = '0;
                seen_next   = '0;
            end
            else
            begin
                sum_next    = sum_upd;
                cnt_next    = cnt_upd;
                offset_next = offset_upd;
                magic_next  = magic_upd;
                csum_next   = csum_upd;
                seen_next   = seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            offset_reg <= '0;
            magic_reg  <= '0;
            csum_reg   <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            offset_reg <= offset_next;
            magic_reg  <= magic_next;
            csum_reg   <= csum_next;
            seen_reg   <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_word |=> sum_reg == '0 && cnt_reg == '0 && seen_reg == '0)
        else $error("state not cleared after final word");

    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        !cnt_reg[0])
        else $error("byte count odd between files");
`endif

endmodule

@@ sv/pe_image_checksum_top.sv @@
// Top level of the streaming PE image checksum block.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  words    | word_valid   | word_stall   | word_item   (pic_pkg::word_item_t)
//  results  | result_valid | result_stall | result_item (pic_pkg::result_item_t)
//
// One word transaction per cycle, except that a final word stalls while the
// snapshot register is full; only the final word of a file makes a result
// transaction, by way of the input, snapshot, adjust and result registers.
// Each word goes through the 17-bit end-around fold in the accumulator.
// The DOS header store needs no clearing: every slot is rewritten before the
// header scan reads it, so the block takes words straight out of reset.
// Stalls on the result side back up through the finishing stages; plain
// words keep flowing while a finished result waits.
module pe_image_checksum_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_stall,
    input  pic_pkg::word_item_t   word_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output pic_pkg::result_item_t result_item
);

    // Input register
    logic                in_v_reg;
    pic_pkg::word_item_t in_item_reg;

    // Snapshot of the file's state after its final word
    logic           s1_v_reg;
    pic_pkg::snap_t s1_reg;
    pic_pkg::snap_t snap;

    // First checksum half removed
    logic                            s2_v_reg;
    logic [15:0]                     s2_pa_reg;
    logic [15:0]                     s2_a1_reg;
    logic [pic_pkg::LENGTH_BITS-1:0] s2_count_reg;
    logic [31:0]                     s2_field_reg;
    pic_pkg::status_t                s2_status_reg;

    // Result register
    logic                  res_v_reg;
    pic_pkg::result_item_t res_reg;

    logic        s0_go, s1_free, s1_go, s2_go, step;
    logic [15:0] p_fold, p_a, p_b;

    // Subtract with the borrow folded back in, 16-bit ones' complement style
    function automatic logic [15:0] sub_borrow(input logic [15:0] p, input logic [15:0] a);
        logic [16:0] t;
        t = {1'b0, p} - {1'b0, a};
        return t[15:0] - 16'(t[16]);
    endfunction

    assign s2_go   = ~res_v_reg | ~result_stall;
    assign s1_go   = ~s2_v_reg | s2_go;
    assign s1_free = ~s1_v_reg | s1_go;
    assign s0_go   = ~in_item_reg.last_word | s1_free;
    assign step    = in_v_reg & s0_go;

    assign word_stall   = in_v_reg & ~s0_go;
    assign result_valid = res_v_reg;
    assign result_item  = res_reg;

    pic_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .snap  (snap)
    );

    assign p_fold = s1_reg.sum[15:0] + 16'(s1_reg.sum[16]);
    assign p_a    = sub_borrow(p_fold, s1_reg.field[15:0]);
    assign p_b    = sub_borrow(s2_pa_reg, s2_a1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (!word_stall)
            begin
                in_v_reg <= word_valid;
            end
            if (s1_free)
            begin
                s1_v_reg <= step & in_item_reg.last_word;
            end
            if (s1_go)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s2_go)
            begin
                res_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!word_stall && word_valid)
        begin
            in_item_reg <= word_item;
        end
        if (s1_free && step && in_item_reg.last_word)
        begin
            s1_reg <= snap;
        end
        if (s1_go && s1_v_reg)
        begin
            s2_pa_reg     <= p_a;
            s2_a1_reg     <= s1_reg.field[31:16];
            s2_count_reg  <= s1_reg.count;
            s2_field_reg  <= s1_reg.field;
            s2_status_reg <= s1_reg.status;
        end
        if (s2_go && s2_v_reg)
        begin
            res_reg.image_checksum  <= 32'(p_b) + 32'(s2_count_reg);
            res_reg.stored_checksum <= s2_field_reg;
            res_reg.status          <= s2_status_reg;
        end
    end

`ifndef SYNTHESIS
    a_last_reaches_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_item_reg.last_word |=> s1_v_reg)
        else $error("final word did not reach snapshot stage");

    a_adjust_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg && !s2_go |=> s2_v_reg && $stable(s2_pa_reg) && $stable(s2_count_reg))
        else $error("adjust stage lost or changed a held result");

    a_stored_only_adjusted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.stored_checksum != 32'h0
            |-> result_item.status == pic_pkg::ST_ADJUSTED)
        else $error("stored checksum reported for unadjusted image");
`endif

endmodule
